/* rtl/crc16_frame_appender_macros.svh */
// assertion helpers used by the queue
`ifndef CRC16_FRAME_APPENDER_MACROS_SVH
`define CRC16_FRAME_APPENDER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CRCFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while in reset
`define CRCFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/crcfa_pkg.sv */
package crcfa_pkg;

   typedef struct packed {
      logic [7:0] data;
      logic       eof;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] count;
   } release_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY_REFL = 16'hA001;
   localparam logic [7:0]  ASCII_COLON   = 8'h3A;
   localparam logic [7:0]  ASCII_ZERO    = 8'h30;
   localparam logic [7:0]  ASCII_LETTER  = 8'h37;

   // per-beat output limit and overflow hold limit of the link framing
   localparam logic [3:0] MAX_OUT    = 4'd6;
   localparam logic [3:0] HOLD_LIMIT = 4'd8;
   localparam logic [3:0] WORK_LIMIT = 4'd14;

   localparam int STEP_SLOTS = 8;

   localparam logic CSR_FRAME_MODE = 1'b0;
   localparam logic CSR_APPEND_CRC = 1'b1;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFL;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] d;
      if (nib < 4'd10) begin
         d = ASCII_ZERO + {4'h0, nib};
      end else begin
         d = ASCII_LETTER + {4'h0, nib};
      end
      return d;
   endfunction

endpackage

/* rtl/crc16_frame_appender.sv */
// channel  | ports                                   | moves
// ---------+-----------------------------------------+------------------------------
// req      | req_valid/req_ready, data_byte, last    | one frame byte per beat
// rsp      | rsp_valid/rsp_ready, out_byte, eof      | one link byte per beat
// csr      | csr_wr_en, csr_index, csr_wdata         | frame_mode, append_crc writes
//
// a req beat waits while the front's one-item-per-cycle expander feeds that beat's link bytes
// into the queue; it stalls while the queue is full. rsp bytes leave one per cycle while
// rsp_ready is high and bytes are released, via the output register loaded on each queue pop;
// reset (synchronous) restarts the crc at 0xffff, empties the queue and holds nothing
// either side stalls alone: the queue absorbs bursts, req waits while expanding and in reset
module crc16_frame_appender #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_of_frame,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_end_of_frame,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic       csr_wdata
);

   // control registers
   logic frame_mode_ff;
   logic append_crc_ff;

   // front to queue and front to back
   logic                        push_en;
   crcfa_pkg::item_type         push_item;
   crcfa_pkg::release_type      rel;
   crcfa_pkg::queue_status_type q_status;
   crcfa_pkg::item_type         q_head;
   logic                        pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_mode_ff <= 1'b0;
         append_crc_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            crcfa_pkg::CSR_FRAME_MODE: frame_mode_ff <= csr_wdata;
            crcfa_pkg::CSR_APPEND_CRC: append_crc_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front: takes each beat, runs the crc, builds the link bytes and feeds them in order;
   // it also tracks how many bytes the link framing lets out per beat and which are held
   crcfa_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_of_frame (req_last_of_frame),
      .frame_mode        (frame_mode_ff),
      .append_crc        (append_crc_ff),
      .q_status          (q_status),
      .push_en           (push_en),
      .push_item         (push_item),
      .rel               (rel)
   );

   // short queue between the two halves
   crcfa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_en),
      .push_item (push_item),
      .pop       (pop),
      .head      (q_head),
      .status    (q_status)
   );

   // back: lets released bytes out through the output register; held bytes wait
   // for the next req beat to release them
   crcfa_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .rel              (rel),
      .q_empty          (q_status.empty),
      .q_head           (q_head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule

/* rtl/crcfa_front.sv */
module crcfa_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_last_of_frame,
   input  logic                       frame_mode,
   input  logic                       append_crc,
   input  crcfa_pkg::queue_status_type q_status,
   output logic                       push_en,
   output crcfa_pkg::item_type        push_item,
   output crcfa_pkg::release_type     rel
);

   crcfa_pkg::item_type    items_ff [crcfa_pkg::STEP_SLOTS];
   crcfa_pkg::item_type    list_in  [crcfa_pkg::STEP_SLOTS];
   logic [2:0]             cnt_ff, idx_ff;
   logic                   busy_ff;
   logic [15:0]            crc_ff, crc_next;
   logic                   start_ff;
   logic [3:0]             hold_ff, hold_in;
   crcfa_pkg::release_type rel_ff;

   logic                   accept, last_push, add;
   logic [2:0]             p, kept, n_out;
   logic [3:0]             work;
   logic [7:0]             src_byte [3];
   logic                   src_en   [3];
   logic                   src_end  [3];

   assign crc_next = crcfa_pkg::crc_update(crc_ff, req_data_byte);
   assign add      = append_crc & req_last_of_frame;

   assign src_byte[0] = req_data_byte;
   assign src_en[0]   = 1'b1;
   assign src_end[0]  = req_last_of_frame & ~append_crc;
   assign src_byte[1] = crc_next[7:0];
   assign src_en[1]   = add;
   assign src_end[1]  = 1'b0;
   assign src_byte[2] = crc_next[15:8];
   assign src_en[2]   = add;
   assign src_end[2]  = 1'b1;

   // lay the beat's items out in link order
   always_comb begin
      for (int i = 0; i < crcfa_pkg::STEP_SLOTS; i++) begin
         list_in[i] = '0;
      end
      p = 3'd0;
      if (frame_mode && start_ff) begin
         list_in[p] = '{data: crcfa_pkg::ASCII_COLON, eof: 1'b0};
         p = p + 3'd1;
      end
      for (int s = 0; s < 3; s++) begin
         if (src_en[s]) begin
            if (frame_mode) begin
               list_in[p] = '{data: crcfa_pkg::hex_digit(src_byte[s][7:4]), eof: 1'b0};
               list_in[p + 3'd1] = '{data: crcfa_pkg::hex_digit(src_byte[s][3:0]),
                                     eof: src_end[s]};
               p = p + 3'd2;
            end else begin
               list_in[p] = '{data: src_byte[s], eof: src_end[s]};
               p = p + 3'd1;
            end
         end
      end
   end

   // per-beat release and hold bookkeeping
   always_comb begin
      work  = hold_ff + {1'b0, p};
      n_out = (work > crcfa_pkg::MAX_OUT) ? crcfa_pkg::MAX_OUT[2:0] : work[2:0];
      if (work > crcfa_pkg::WORK_LIMIT) begin
         hold_in = crcfa_pkg::HOLD_LIMIT;
         kept    = p - 3'd1;
      end else begin
         hold_in = (work > crcfa_pkg::MAX_OUT) ? work - crcfa_pkg::MAX_OUT : 4'd0;
         kept    = p;
      end
   end

   assign push_en   = busy_ff & ~q_status.full;
   assign push_item = items_ff[idx_ff];
   assign last_push = push_en & (idx_ff == cnt_ff - 3'd1);
   assign req_ready = ~reset & (~busy_ff | last_push);
   assign accept    = req_valid & req_ready;
   assign rel       = rel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= 3'd0;
         cnt_ff   <= 3'd0;
         crc_ff   <= crcfa_pkg::CRC_INIT;
         start_ff <= 1'b1;
         hold_ff  <= 4'd0;
         rel_ff   <= '0;
      end else begin
         rel_ff.valid <= accept;
         if (accept) begin
            busy_ff      <= 1'b1;
            idx_ff       <= 3'd0;
            cnt_ff       <= kept;
            crc_ff       <= req_last_of_frame ? crcfa_pkg::CRC_INIT : crc_next;
            start_ff     <= req_last_of_frame;
            hold_ff      <= hold_in;
            rel_ff.count <= n_out;
         end else if (push_en) begin
            idx_ff <= idx_ff + 3'd1;
            if (last_push) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         items_ff <= list_in;
      end
   end

endmodule

/* rtl/crcfa_queue.sv */
`include "crc16_frame_appender_macros.svh"

module crcfa_queue #(
   parameter int DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  crcfa_pkg::item_type         push_item,
   input  logic                        pop,
   output crcfa_pkg::item_type         head,
   output crcfa_pkg::queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   crcfa_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign head         = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wrap_inc(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= wrap_inc(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `CRCFA_ASSERT_NOW(a_no_overflow, clock, reset, push, !status.full || pop, "queue overflow")
   `CRCFA_ASSERT_NOW(a_no_underflow, clock, reset, pop, !status.empty, "queue underflow")
   `CRCFA_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count did not rise")
   `CRCFA_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

/* rtl/crcfa_back.sv */
module crcfa_back #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  crcfa_pkg::release_type rel,
   input  logic                   q_empty,
   input  crcfa_pkg::item_type    q_head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_end_of_frame
);

   // released items wait in the queue or in the front's expander
   localparam int AVAIL_W = $clog2(QUEUE_DEPTH + 8);

   logic [AVAIL_W-1:0]  avail_ff, avail_in;
   logic                valid_ff;
   crcfa_pkg::item_type out_ff;

   assign pop = ~q_empty & (avail_ff != '0) & (~valid_ff | rsp_ready);

   always_comb begin
      avail_in = avail_ff;
      if (rel.valid) begin
         avail_in = avail_in + AVAIL_W'(rel.count);
      end
      if (pop) begin
         avail_in = avail_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         avail_ff <= avail_in;
         if (pop) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= q_head;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = out_ff.data;
   assign rsp_end_of_frame = out_ff.eof;

endmodule

/* dv/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // one link byte as it leaves the block
   typedef struct packed {
      logic [7:0] value;
      logic       eof;
   } link_byte_type;

   // directed stimulus: register setting, frame byte, and where obvious the link bytes by hand
   typedef struct packed {
      logic        mode;
      logic        append;
      logic [7:0]  data;
      logic        last;
      logic [1:0]  n_exp;
      logic [23:0] exp;
   } frame_byte_row_type;

   localparam int LINK_BYTES_PER_BEAT = 6;
   localparam int HOLD_SLOTS          = 8;
   localparam int STAGE_SLOTS         = 16;
   localparam int SETTLE_CYCLES       = 10;
   localparam int HOLD_OFF_CYCLES     = 300;
   localparam int DIRECTED_ROWS       = 26;
   localparam int PHASE_COUNT         = 8;
   localparam int PHASE_BEATS         = 48;
   localparam int PRESSURE_BEATS      = 40;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_data_byte;
   logic       req_last_of_frame;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_end_of_frame;
   logic       csr_wr_en;
   logic       csr_index;
   logic       csr_wdata;

   crc16_frame_appender u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_of_frame (req_last_of_frame),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_frame  (rsp_end_of_frame),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor state
   logic          frame_mode_q = 1'b0;
   logic          append_crc_q = 1'b1;
   logic [15:0]   crc_acc      = 16'hFFFF;
   logic          at_start     = 1'b1;
   link_byte_type hold_q[$];          // link bytes over the per-beat limit, released next beat
   link_byte_type stage_q[$];         // everything one beat makes, before the split
   link_byte_type link_bytes_due[$];  // expected link bytes, oldest first

   // hand-typed expectation travelling with the current req beat (0 means predicted)
   int          typed_n = 0;
   logic [23:0] typed_bytes = '0;

   int mismatches        = 0;
   int link_bytes_seen   = 0;
   int frame_bytes_taken = 0;
   int frames_done       = 0;
   int bytes_dropped     = 0;

   // traffic shaping, owned by the main sequence
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_off_toggle = 1'b0;
   bit hold_off_seen   = 1'b0;

   int send_idle_mix [4] = '{0, 78, 0, 14};
   int rsp_stall_mix [4] = '{0, 0, 78, 14};
   // {frame_mode, append_crc} per random phase
   logic [1:0] phase_setting [PHASE_COUNT] = '{2'b01, 2'b11, 2'b00, 2'b10,
                                               2'b11, 2'b01, 2'b10, 2'b00};

   frame_byte_row_type stim_rows [DIRECTED_ROWS] = '{
      // binary with crc, straight after reset
      '{1'b0, 1'b1, 8'h00, 1'b1, 2'd3, 24'h00BF40},
      '{1'b0, 1'b1, 8'hFF, 1'b1, 2'd3, 24'hFFFF00},
      '{1'b0, 1'b1, 8'h01, 1'b0, 2'd0, 24'h000000},
      '{1'b0, 1'b1, 8'h80, 1'b1, 2'd0, 24'h000000},
      // binary, no crc
      '{1'b0, 1'b0, 8'hFF, 1'b1, 2'd1, 24'hFF0000},
      '{1'b0, 1'b0, 8'h55, 1'b0, 2'd1, 24'h550000},
      '{1'b0, 1'b0, 8'hAA, 1'b1, 2'd1, 24'hAA0000},
      // text, no crc: colon only on a frame's first byte
      '{1'b1, 1'b0, 8'h00, 1'b1, 2'd3, 24'h3A3030},
      '{1'b1, 1'b0, 8'hA5, 1'b1, 2'd3, 24'h3A4135},
      '{1'b1, 1'b0, 8'hFF, 1'b0, 2'd3, 24'h3A4646},
      '{1'b1, 1'b0, 8'h09, 1'b1, 2'd2, 24'h303900},
      // text with crc, then a run of one-byte frames that overflows the hold store
      '{1'b1, 1'b1, 8'h12, 1'b0, 2'd3, 24'h3A3132},
      '{1'b1, 1'b1, 8'h34, 1'b1, 2'd0, 24'h000000},
      '{1'b1, 1'b1, 8'h00, 1'b1, 2'd0, 24'h000000},
      '{1'b1, 1'b1, 8'hFF, 1'b1, 2'd0, 24'h000000},
      '{1'b1, 1'b1, 8'h80, 1'b1, 2'd0, 24'h000000},
      '{1'b1, 1'b1, 8'h7F, 1'b1, 2'd0, 24'h000000},
      '{1'b1, 1'b1, 8'h01, 1'b1, 2'd0, 24'h000000},
      '{1'b1, 1'b1, 8'hFE, 1'b1, 2'd0, 24'h000000},
      '{1'b1, 1'b1, 8'h5A, 1'b1, 2'd0, 24'h000000},
      '{1'b1, 1'b1, 8'hA5, 1'b1, 2'd0, 24'h000000},
      '{1'b1, 1'b1, 8'h10, 1'b1, 2'd0, 24'h000000},
      // mode flips in mid-frame, both ways
      '{1'b1, 1'b1, 8'h3C, 1'b0, 2'd0, 24'h000000},
      '{1'b0, 1'b1, 8'hC3, 1'b1, 2'd0, 24'h000000},
      '{1'b0, 1'b1, 8'h66, 1'b0, 2'd0, 24'h000000},
      '{1'b1, 1'b1, 8'h99, 1'b1, 2'd0, 24'h000000}
   };

   // ---------------------------------------------------------------- predictor
   // reflected crc-16, one byte, bit-serial
   function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
   endfunction

   function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
      return (nib < 4'd10) ? 8'h30 + {4'h0, nib} : 8'h41 + {4'h0, nib} - 8'd10;
   endfunction

   function automatic void stage_link_byte(input logic [7:0] v, input logic e);
      if (stage_q.size() < STAGE_SLOTS) stage_q.push_back(link_byte_type'{v, e});
   endfunction

   // one frame or crc byte: raw in binary, two hex digits in text
   function automatic void stage_frame_byte(input logic [7:0] b, input logic e, input logic text);
      if (text) begin
         stage_link_byte(ascii_hex(b[7:4]), 1'b0);
         stage_link_byte(ascii_hex(b[3:0]), e);
      end else begin
         stage_link_byte(b, e);
      end
   endfunction

   task automatic predict_link_bytes(input logic [7:0] b, input logic last, input int n_typed,
                                     input logic [23:0] typed);
      int   n_out;
      int   k;
      logic text;
      logic add;
      text = frame_mode_q;
      add  = append_crc_q;
      // held bytes from earlier beats go first
      stage_q = hold_q;
      hold_q.delete();
      if (text && at_start) stage_link_byte(crcfa_pkg::ASCII_COLON, 1'b0);
      at_start = 1'b0;
      crc_acc = crc16_next(crc_acc, b);
      stage_frame_byte(b, last && !add, text);
      if (last) begin
         if (add) begin
            stage_frame_byte(crc_acc[7:0], 1'b0, text);
            stage_frame_byte(crc_acc[15:8], 1'b1, text);
         end
         crc_acc  = 16'hFFFF;
         at_start = 1'b1;
         frames_done++;
      end
      n_out = (stage_q.size() < LINK_BYTES_PER_BEAT) ? stage_q.size() : LINK_BYTES_PER_BEAT;
      if (n_typed != 0) begin
         for (k = 0; k < n_typed; k++)
            link_bytes_due.push_back(link_byte_type'{typed[23 - 8 * k -: 8],
                                                     last && (k == n_typed - 1)});
      end else begin
         for (k = 0; k < n_out; k++) link_bytes_due.push_back(stage_q[k]);
      end
      // the rest waits for the next beat, what does not fit is lost
      for (k = n_out; k < stage_q.size(); k++) begin
         if (hold_q.size() < HOLD_SLOTS) hold_q.push_back(stage_q[k]);
         else bytes_dropped++;
      end
   endtask

   // ---------------------------------------------------------------- monitor and scoreboard
   // everything sampled at the rising edge; inputs only move on the falling edge
   always @(posedge clock) begin
      link_byte_type want;
      if (!reset) begin
         if (csr_wr_en) begin
            if (csr_index == crcfa_pkg::CSR_FRAME_MODE) frame_mode_q = csr_wdata;
            else append_crc_q = csr_wdata;
         end
         if (req_valid && req_ready) begin
            frame_bytes_taken++;
            predict_link_bytes(req_data_byte, req_last_of_frame, typed_n, typed_bytes);
         end
         if (rsp_valid && rsp_ready) begin
            if (link_bytes_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected link byte %h eof %b", $realtime, rsp_out_byte,
                           rsp_end_of_frame);
            end else begin
               want = link_bytes_due.pop_front();
               link_bytes_seen++;
               if (rsp_out_byte !== want.value || rsp_end_of_frame !== want.eof) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: link byte %0d: expected %h eof %b, got %h eof %b",
                              $realtime, link_bytes_seen, want.value, want.eof,
                              rsp_out_byte, rsp_end_of_frame);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   // random stalls, plus one long hold-off when the main sequence flips the toggle
   initial begin : rsp_side
      logic armed;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         armed = (hold_off_toggle != hold_off_seen);
         @(negedge clock);
         if (armed) begin
            hold_off_seen = hold_off_toggle;
            rsp_ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------- sender
   logic cur_text = 1'b0;
   logic cur_add  = 1'b1;
   int   frame_left = 0;
   bit   one_byte_frames = 1'b0;

   // offer one frame byte and hold it until the beat is taken; returns on the next falling edge
   task automatic send_frame_byte(input logic [7:0] b, input logic last, input int n_typed,
                                  input logic [23:0] typed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid         = 1'b1;
      req_data_byte     = b;
      req_last_of_frame = last;
      typed_n           = n_typed;
      typed_bytes       = typed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_byte();
      int         pick;
      logic [7:0] b;
      if (frame_left == 0) begin
         pick = $urandom_range(99);
         if (one_byte_frames || pick < 25) frame_left = 1;
         else if (pick < 90) frame_left = $urandom_range(8, 2);
         else frame_left = $urandom_range(40, 9);
      end
      pick = $urandom_range(9);
      if (pick == 0) b = 8'h00;
      else if (pick == 1) b = 8'hFF;
      else b = $urandom_range(255);
      frame_left--;
      send_frame_byte(b, frame_left == 0, 0, 24'h000000);
   endtask

   // registers change only once every expected byte is out and the pipe has settled
   task automatic set_link_mode(input logic text, input logic add);
      req_valid = 1'b0;
      while (link_bytes_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = crcfa_pkg::CSR_FRAME_MODE;
      csr_wdata = text;
      @(negedge clock);
      csr_index = crcfa_pkg::CSR_APPEND_CRC;
      csr_wdata = add;
      @(negedge clock);
      csr_wr_en = 1'b0;
      cur_text  = text;
      cur_add   = add;
   endtask

   // ---------------------------------------------------------------- main sequence
   initial begin : main_seq
      int row;
      int phase;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data_byte     = 8'h00;
      req_last_of_frame = 1'b0;
      csr_wr_en         = 1'b0;
      csr_index         = crcfa_pkg::CSR_FRAME_MODE;
      csr_wdata         = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table, no idling; registers are still at their reset values for the first rows
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (stim_rows[row].mode != cur_text || stim_rows[row].append != cur_add)
            set_link_mode(stim_rows[row].mode, stim_rows[row].append);
         send_frame_byte(stim_rows[row].data, stim_rows[row].last, stim_rows[row].n_exp,
                         stim_rows[row].exp);
      end

      // random phases: each register setting under two of the idle mixes; phases may end mid-frame
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         set_link_mode(phase_setting[phase][1], phase_setting[phase][0]);
         send_idle_pct = send_idle_mix[phase % 4];
         rsp_stall_pct = rsp_stall_mix[phase % 4];
         repeat (PHASE_BEATS) send_random_byte();
      end

      // back-pressure: text with crc, one-byte frames at full rate into a long output hold-off
      set_link_mode(1'b1, 1'b1);
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      one_byte_frames = 1'b1;
      hold_off_toggle = ~hold_off_toggle;
      repeat (PRESSURE_BEATS) send_random_byte();

      // drain
      req_valid = 1'b0;
      while (link_bytes_due.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);

      $display("covered %0d frame bytes in %0d frames, %0d link bytes checked, %0d held lost",
               frame_bytes_taken, frames_done, link_bytes_seen, bytes_dropped);
      $display("binary and text framing with and without crc, all idle mixes, one long hold-off");
      if (mismatches == 0 && link_bytes_due.size() == 0) begin
         $display("crc16_frame_appender verification clean");
      end else begin
         $display("crc16_frame_appender verification failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("crc16_frame_appender verification failed");
      $finish;
   end

endmodule
